// ===== hw/rtl/tmpr_pkg.sv =====
// Shared types, codes and constants of the tile map pixel renderer.
package tmpr_pkg;

    // Item codes on the action field.
    localparam logic [1:0] ACT_MAP_WR = 2'd0;
    localparam logic [1:0] ACT_PAT_WR = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_ADDR_MODE = 1'b0;
    localparam logic CFG_PALETTE   = 1'b1;

    localparam logic       ADDR_MODE_RESET = 1'b1;
    localparam logic [7:0] PALETTE_RESET   = 8'd228;

    // Signed tile numbers are placed around this tile.
    localparam logic [8:0] SIGNED_TILE_BASE = 9'h100;

    // Pattern store: 384 tiles of 8 rows, each row a low and a high bitplane byte.
    // The two planes live in two banks so that a row is read in one access.
    localparam int PAT_DEPTH      = 6144;
    localparam int PAT_BANK_DEPTH = 3072;
    localparam int PAT_BANK_AW    = 12;

    localparam logic [7:0] GRAY_LEVEL0 = 8'd255;
    localparam logic [7:0] GRAY_LEVEL1 = 8'd170;
    localparam logic [7:0] GRAY_LEVEL2 = 8'd85;
    localparam logic [7:0] GRAY_LEVEL3 = 8'd0;

    typedef struct packed {
        logic                   en;
        logic [12:0]            addr;
        logic [7:0]             data;
    } t_pat_wr;

    typedef struct packed {
        logic                   valid;
        logic [PAT_BANK_AW-1:0] row;
        logic [2:0]             x_lo;
    } t_fetch_req;

    // Intensity is 255 minus 85 times the level.
    function automatic logic [7:0] gray_of(input logic [1:0] level);
        logic [7:0] g;
        unique case (level)
            2'd0:    g = GRAY_LEVEL0;
            2'd1:    g = GRAY_LEVEL1;
            2'd2:    g = GRAY_LEVEL2;
            default: g = GRAY_LEVEL3;
        endcase
        return g;
    endfunction

endpackage

// ===== hw/rtl/tmpr_pattern_fetch.sv =====
// Pattern banks, bitplane row read, palette lookup and the output register.
module tmpr_pattern_fetch
    import tmpr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_pat_wr    i_pat_wr,
    input  t_fetch_req i_req,
    output logic       o_req_ready,
    input  logic [7:0] i_palette,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_level,
    output logic [7:0] o_gray
);

    logic [7:0] r_bank_lo [PAT_BANK_DEPTH];
    logic [7:0] r_bank_hi [PAT_BANK_DEPTH];

    logic [7:0] r_lo_q;
    logic [7:0] r_hi_q;
    logic [2:0] r_s2_x;
    logic       r_s2_valid;
    logic       r_out_valid;
    logic [1:0] r_level;
    logic [7:0] r_gray;

    logic       w_out_free;
    logic       w_adv2;
    logic       w_take;
    logic       w_wr_ok;
    logic [2:0] w_bit;
    logic [1:0] w_shade;
    logic [1:0] n_level;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_adv2      = r_s2_valid && w_out_free;
    assign o_req_ready = !r_s2_valid || w_adv2;
    assign w_take      = i_req.valid && o_req_ready;
    assign w_wr_ok     = i_pat_wr.en && ({1'b0, i_pat_wr.addr} < 14'(PAT_DEPTH));

    // Bit 7 - x of each plane; for a 3-bit x that is the complement.
    assign w_bit   = ~r_s2_x;
    assign w_shade = {r_hi_q[w_bit], r_lo_q[w_bit]};
    assign n_level = i_palette[{w_shade, 1'b0} +: 2];

    // Reads take the old contents when a later write lands on the same edge.
    always_ff @(posedge i_clk) begin
        if (w_wr_ok) begin
            if (i_pat_wr.addr[0]) begin
                r_bank_hi[i_pat_wr.addr[12:1]] <= i_pat_wr.data;
            end else begin
                r_bank_lo[i_pat_wr.addr[12:1]] <= i_pat_wr.data;
            end
        end
        if (w_take) begin
            r_lo_q <= r_bank_lo[i_req.row];
            r_hi_q <= r_bank_hi[i_req.row];
            r_s2_x <= i_req.x_lo;
        end
        if (w_adv2) begin
            r_level <= n_level;
            r_gray  <= gray_of(n_level);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_req_ready) begin
                r_s2_valid <= i_req.valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_level     = r_level;
    assign o_gray      = r_gray;

endmodule

// ===== hw/rtl/tile_map_pixel_renderer_core.sv =====
// Top level of the tile map pixel renderer: map store, tile select and configuration.
// A pixel query passes through the map read register, the pattern row register and the output register.
// Throughput: one item per cycle while the output is not stalled; a query makes one map read, then one pattern row read
// across the two bitplane banks, each with one read port and one write port.
// Write items and unused actions complete at acceptance and give no result.
// Reset clears the pipeline and the configuration registers; the stores keep their contents.
module tile_map_pixel_renderer_core
    import tmpr_pkg::*;
#(
    parameter int MAP_ROWS = 64,
    parameter int MAP_COLS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [12:0] i_write_address,
    input  logic [7:0]  i_write_byte,
    input  logic [7:0]  i_pixel_x,
    input  logic [8:0]  i_pixel_y,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_level,
    output logic [7:0]  o_gray
);

    localparam int MAP_DEPTH = MAP_ROWS * MAP_COLS;
    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

    logic [7:0] r_map [MAP_DEPTH];
    logic [7:0] r_map_q;
    logic       r_s1_valid;
    logic [2:0] r_s1_x;
    logic [2:0] r_s1_y;
    logic       r_addr_mode;
    logic [7:0] r_palette;

    logic [5:0]        w_row_tab [64];
    logic [4:0]        w_col_tab [32];
    logic [5:0]        w_row;
    logic [4:0]        w_col;
    logic [12:0]       w_map_lin;
    logic [MAP_AW-1:0] w_map_rd;
    logic              w_accept;
    logic              w_map_wr;
    logic              w_req_ready;
    logic [8:0]        w_tile;
    t_pat_wr           w_pat_wr;
    t_fetch_req        w_req;

    // Tile coordinates wrap around the map; both tables are built at elaboration.
    for (genvar gi = 0; gi < 64; gi++) begin : g_row_tab
        assign w_row_tab[gi] = 6'(gi % MAP_ROWS);
    end
    for (genvar gj = 0; gj < 32; gj++) begin : g_col_tab
        assign w_col_tab[gj] = 5'(gj % MAP_COLS);
    end

    assign w_row     = w_row_tab[i_pixel_y[8:3]];
    assign w_col     = w_col_tab[i_pixel_x[7:3]];
    assign w_map_lin = 13'(w_row) * 13'(MAP_COLS) + 13'(w_col);
    assign w_map_rd  = w_map_lin[MAP_AW-1:0];

    // A new beat is taken only when the first stage is empty or its query moves on in the same
    // edge, so a pattern write never lands ahead of an earlier query's row read.
    assign o_in_ready = !r_s1_valid || w_req_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_map_wr   = w_accept && (i_action == ACT_MAP_WR)
                        && ({1'b0, i_write_address} < 14'(MAP_DEPTH));

    assign w_pat_wr.en   = w_accept && (i_action == ACT_PAT_WR);
    assign w_pat_wr.addr = i_write_address;
    assign w_pat_wr.data = i_write_byte;

    // Signed mode: numbers 0..127 map to tiles 256..383, numbers 128..255 stay as they are.
    assign w_tile = (!r_addr_mode && !r_map_q[7]) ? (SIGNED_TILE_BASE + {1'b0, r_map_q})
                                                   : {1'b0, r_map_q};

    assign w_req.valid = r_s1_valid;
    assign w_req.row   = {w_tile, r_s1_y};
    assign w_req.x_lo  = r_s1_x;

    always_ff @(posedge i_clk) begin
        if (w_map_wr) begin
            r_map[i_write_address[MAP_AW-1:0]] <= i_write_byte;
        end
        if (w_accept) begin
            r_map_q <= r_map[w_map_rd];
            r_s1_x  <= i_pixel_x[2:0];
            r_s1_y  <= i_pixel_y[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_addr_mode <= ADDR_MODE_RESET;
            r_palette   <= PALETTE_RESET;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid && (i_action == ACT_QUERY);
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ADDR_MODE: r_addr_mode <= i_cfg_data[0];
                    CFG_PALETTE:   r_palette   <= i_cfg_data;
                    default:       r_palette   <= r_palette;
                endcase
            end
        end
    end

    tmpr_pattern_fetch u_pattern_fetch (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pat_wr    (w_pat_wr),
        .i_req       (w_req),
        .o_req_ready (w_req_ready),
        .i_palette   (r_palette),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_level     (o_level),
        .o_gray      (o_gray)
    );

endmodule

// ===== sim/tile_map_pixel_renderer_core_tb.sv =====
// Self-checking testbench of the tile map pixel renderer with its own pixel predictor.
module tile_map_pixel_renderer_core_tb;
    import tmpr_pkg::*;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         MAP_CELLS    = 2048;
    localparam int         ADDR_TOP     = 8191;
    localparam int         HOLD_CYCLES  = 64;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         STALL_LIMIT  = 1000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_action;
    logic [12:0] i_write_address;
    logic [7:0]  i_write_byte;
    logic [7:0]  i_pixel_x;
    logic [8:0]  i_pixel_y;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_level;
    logic [7:0]  o_gray;

    // Predictor state, updated only by the scoreboard at reset, configuration writes and accepted beats.
    logic [7:0] map_model [MAP_CELLS];
    logic [7:0] pat_model [PAT_DEPTH];
    logic       mode_unsigned;
    logic [7:0] palette_model;
    logic [1:0] pending_levels [$];
    int         mismatch_count = 0;

    // What the stimulus side has written so far, so that no query reads an empty entry.
    logic [7:0] gen_map_val [MAP_CELLS];
    bit         gen_map_set [MAP_CELLS];
    bit         gen_pat_set [PAT_DEPTH];
    logic       gen_mode = ADDR_MODE_RESET;
    int         counted_items = 0;

    bit tx_idle_en   = 1'b1;
    bit rx_idle_en   = 1'b1;
    bit idle_allowed = 1'b1;
    bit hold_out     = 1'b0;
    int idle_cycles  = 0;

    tile_map_pixel_renderer_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_write_address (i_write_address),
        .i_write_byte    (i_write_byte),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_level         (o_level),
        .o_gray          (o_gray)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Signed numbers 0..127 land on tiles 256..383, numbers 128..255 stay where they are.
    function automatic logic [8:0] tile_of(input logic [7:0] number, input logic unsigned_mode);
        if (unsigned_mode || number[7]) begin
            return {1'b0, number};
        end
        return SIGNED_TILE_BASE + 9'(number);
    endfunction

    function automatic logic [1:0] pixel_level(input logic [7:0] px, input logic [8:0] py);
        logic [12:0] row_addr;
        logic [2:0]  bit_sel;
        logic [1:0]  shade;
        row_addr = {tile_of(map_model[{py[8:3], px[7:3]}], mode_unsigned), py[2:0], 1'b0};
        bit_sel  = ~px[2:0];
        shade    = {pat_model[row_addr | 13'd1][bit_sel], pat_model[row_addr][bit_sel]};
        return palette_model[{shade, 1'b0} +: 2];
    endfunction

    // Input beats are predicted before output beats are checked, in one process.
    always @(posedge i_clk) begin : scoreboard
        logic [1:0] want_level;
        logic [7:0] want_gray;
        if (!i_rst_n) begin
            mode_unsigned = ADDR_MODE_RESET;
            palette_model = PALETTE_RESET;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ADDR_MODE) begin
                    mode_unsigned = i_cfg_data[0];
                end else begin
                    palette_model = i_cfg_data;
                end
            end
            if (i_in_valid && o_in_ready) begin
                case (i_action)
                    ACT_MAP_WR: begin
                        if (i_write_address < MAP_CELLS) begin
                            map_model[i_write_address[10:0]] = i_write_byte;
                        end
                    end
                    ACT_PAT_WR: begin
                        if (i_write_address < PAT_DEPTH) begin
                            pat_model[i_write_address] = i_write_byte;
                        end
                    end
                    ACT_QUERY: begin
                        pending_levels.push_back(pixel_level(i_pixel_x, i_pixel_y));
                    end
                    default: begin
                    end
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_levels.size() == 0) begin
                    $error("level: expected no beat, got %0d (gray %0d)", o_level, o_gray);
                    mismatch_count++;
                end else begin
                    want_level = pending_levels.pop_front();
                    want_gray  = 8'd255 - 8'd85 * want_level;
                    if (o_level !== want_level) begin
                        $error("level: expected %0d, got %0d", want_level, o_level);
                        mismatch_count++;
                    end
                    if (o_gray !== want_gray) begin
                        $error("gray: expected %0d, got %0d", want_gray, o_gray);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("tile_map_pixel_renderer_core_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Output side: random stalls, plus one long hold-off when the test asks for it.
    initial begin : out_ready_driver
        i_out_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_out) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_out = 1'b0;
                i_out_ready <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Fields that the action does not use carry random values.
    task automatic send_item(input logic [1:0] act, input logic [12:0] addr,
                             input logic [7:0] data, input logic [7:0] px,
                             input logic [8:0] py);
        bit map_hit;
        bit pat_hit;
        map_hit = (act == ACT_MAP_WR) && (addr < MAP_CELLS);
        pat_hit = (act == ACT_PAT_WR) && (addr < PAT_DEPTH);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        if (act == ACT_QUERY) begin
            i_write_address <= 13'($urandom);
            i_write_byte    <= 8'($urandom);
            i_pixel_x       <= px;
            i_pixel_y       <= py;
        end else begin
            i_write_address <= addr;
            i_write_byte    <= data;
            i_pixel_x       <= 8'($urandom);
            i_pixel_y       <= 9'($urandom);
        end
        if (map_hit) begin
            gen_map_val[addr[10:0]] = data;
            gen_map_set[addr[10:0]] = 1'b1;
        end
        if (pat_hit) begin
            gen_pat_set[addr] = 1'b1;
        end
        counted_items++;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
    endtask

    // Loads the map cell and the tile row first where they were never written.
    task automatic query_pixel(input logic [7:0] px, input logic [8:0] py);
        logic [10:0] map_cell;
        logic [12:0] base;
        map_cell = {py[8:3], px[7:3]};
        if (!gen_map_set[map_cell]) begin
            send_item(ACT_MAP_WR, 13'(map_cell), 8'($urandom), '0, '0);
        end
        base = {tile_of(gen_map_val[map_cell], gen_mode), py[2:0], 1'b0};
        if (!gen_pat_set[base]) begin
            send_item(ACT_PAT_WR, base, 8'($urandom), '0, '0);
        end
        if (!gen_pat_set[base | 13'd1]) begin
            send_item(ACT_PAT_WR, base | 13'd1, 8'($urandom), '0, '0);
        end
        send_item(ACT_QUERY, '0, '0, px, py);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic unsigned_mode, input logic [7:0] pal);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ADDR_MODE;
        i_cfg_data  <= {7'd0, unsigned_mode};
        @(posedge i_clk);
        i_cfg_index <= CFG_PALETTE;
        i_cfg_data  <= pal;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        gen_mode = unsigned_mode;
    endtask

    // Much of the traffic goes to a small hot corner of the map so that tiles are read many times.
    task automatic random_items(input int n);
        int          stop_at;
        int          pick;
        logic [10:0] map_cell;
        stop_at = counted_items + n;
        while (counted_items < stop_at) begin
            if (idle_allowed && $urandom_range(0, 39) == 0) begin
                tx_idle_en = $urandom_range(0, 1);
                rx_idle_en = $urandom_range(0, 1);
            end
            pick = $urandom_range(0, 99);
            map_cell = {6'($urandom_range(0, 3)), 5'($urandom_range(0, 3))};
            if (pick < 30) begin
                query_pixel({map_cell[4:0], 3'($urandom)}, {map_cell[10:5], 3'($urandom)});
            end else if (pick < 55) begin
                query_pixel(8'($urandom), 9'($urandom));
            end else if (pick < 65) begin
                send_item(ACT_MAP_WR, 13'(map_cell), 8'($urandom), '0, '0);
            end else if (pick < 72) begin
                send_item(ACT_MAP_WR, 13'($urandom_range(0, MAP_CELLS - 1)), 8'($urandom),
                          '0, '0);
            end else if (pick < 80) begin
                send_item(ACT_PAT_WR, 13'($urandom_range(0, PAT_DEPTH - 1)), 8'($urandom),
                          '0, '0);
            end else if (pick < 85) begin
                if (gen_map_set[map_cell]) begin
                    send_item(ACT_PAT_WR, {tile_of(gen_map_val[map_cell], gen_mode),
                              4'($urandom)}, 8'($urandom), '0, '0);
                end
            end else if (pick < 90) begin
                send_item(ACT_MAP_WR, 13'($urandom_range(MAP_CELLS, ADDR_TOP)), 8'($urandom),
                          '0, '0);
            end else if (pick < 95) begin
                send_item(ACT_PAT_WR, 13'($urandom_range(PAT_DEPTH, ADDR_TOP)), 8'($urandom),
                          '0, '0);
            end else begin
                send_item(ACT_UNUSED, 13'($urandom), 8'($urandom), '0, '0);
            end
        end
    endtask

    task automatic test_unsigned_tiles();
        // Tile 0, row 0: planes 0x55 and 0x33 give shades 0 to 3 on x = 0 to 3.
        send_item(ACT_MAP_WR, 13'd0, 8'd0, '0, '0);
        send_item(ACT_PAT_WR, 13'd0, 8'h55, '0, '0);
        send_item(ACT_PAT_WR, 13'd1, 8'h33, '0, '0);
        for (int x = 0; x < 4; x++) begin
            query_pixel(8'(x), 9'd0);
        end
        // Last map cell, highest unsigned tile, last tile row.
        send_item(ACT_MAP_WR, 13'd2047, 8'hFF, '0, '0);
        send_item(ACT_PAT_WR, 13'd4094, 8'hFF, '0, '0);
        send_item(ACT_PAT_WR, 13'd4095, 8'h00, '0, '0);
        query_pixel(8'd255, 9'd511);
        // Writes past the end of either store and the unused action must change nothing.
        send_item(ACT_MAP_WR, 13'd2048, 8'hFF, '0, '0);
        send_item(ACT_MAP_WR, 13'h1FFF, 8'hFF, '0, '0);
        send_item(ACT_PAT_WR, 13'd6144, 8'hFF, '0, '0);
        send_item(ACT_PAT_WR, 13'h1FFF, 8'hFF, '0, '0);
        send_item(ACT_UNUSED, 13'($urandom), 8'($urandom), '0, '0);
        query_pixel(8'd0, 9'd0);
        query_pixel(8'd3, 9'd0);
    endtask

    task automatic test_signed_tiles();
        set_config(1'b0, PALETTE_RESET);
        // Number 127 is the top tile, 383.
        send_item(ACT_MAP_WR, 13'd1, 8'd127, '0, '0);
        send_item(ACT_PAT_WR, 13'd6142, 8'hFF, '0, '0);
        send_item(ACT_PAT_WR, 13'd6143, 8'hFF, '0, '0);
        query_pixel(8'd15, 9'd7);
        // Number 128 stays on tile 128.
        send_item(ACT_MAP_WR, 13'd2, 8'h80, '0, '0);
        send_item(ACT_PAT_WR, 13'd2048, 8'h80, '0, '0);
        send_item(ACT_PAT_WR, 13'd2049, 8'h00, '0, '0);
        query_pixel(8'd16, 9'd0);
        // Number 0 now selects tile 256.
        send_item(ACT_PAT_WR, 13'd4096, 8'h00, '0, '0);
        send_item(ACT_PAT_WR, 13'd4097, 8'h80, '0, '0);
        query_pixel(8'd0, 9'd0);
    endtask

    task automatic test_palette_extremes();
        set_config(1'b0, 8'h00);
        random_items(300);
        wait_drained();
        set_config(1'b1, 8'hFF);
        random_items(300);
        wait_drained();
        set_config(1'b0, 8'h1B);
        random_items(300);
        wait_drained();
        set_config(1'b1, 8'($urandom));
        random_items(250);
        wait_drained();
    endtask

    // The output side stops for a long stretch while beats keep coming in.
    task automatic test_backpressure();
        idle_allowed = 1'b0;
        tx_idle_en   = 1'b0;
        rx_idle_en   = 1'b0;
        hold_out     = 1'b1;
        random_items(120);
        wait_drained();
        idle_allowed = 1'b1;
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
    endtask

    task automatic test_steady_stream();
        idle_allowed = 1'b0;
        tx_idle_en   = 1'b0;
        rx_idle_en   = 1'b0;
        set_config(1'($urandom), 8'($urandom));
        random_items(680);
        wait_drained();
    endtask

    initial begin : stimulus
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_ADDR_MODE;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_action        <= ACT_QUERY;
        i_write_address <= '0;
        i_write_byte    <= '0;
        i_pixel_x       <= '0;
        i_pixel_y       <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_unsigned_tiles();
        wait_drained();
        test_signed_tiles();
        wait_drained();
        test_palette_extremes();
        test_backpressure();
        test_steady_stream();
        if (mismatch_count == 0) begin
            $display("tile_map_pixel_renderer_core_tb: done, clean");
        end else begin
            $display("tile_map_pixel_renderer_core_tb: done, errors");
        end
        $finish;
    end

endmodule
